### src/per_flow_delay_jitter_stats_defines.svh
// Assertion macros shared by the per-flow statistics checker.
// Needs nothing else; include by bare file name.
`ifndef PER_FLOW_DELAY_JITTER_STATS_DEFINES_SVH
`define PER_FLOW_DELAY_JITTER_STATS_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PFDJS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFDJS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/pfdjs_pkg.sv
// Package for the per-flow delay/jitter statistics block: widths, command codes,
// table entry layout and controller/datapath handshake structs. No dependencies.
package pfdjs_pkg;

  localparam int NODE_COUNT = 64;
  localparam int DELAY_BITS = 32;

  localparam int IDX_W    = $clog2(NODE_COUNT);
  localparam int NODE_W   = 6;
  localparam int DELAY_W  = 32;
  localparam int JITTER_W = 32;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 32;

  localparam logic [1:0] CMD_RECV = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic [DELAY_BITS-1:0] last_delay;
    logic [SUM_W-1:0]      delay_sum;
    logic [SUM_W-1:0]      jitter_sum;
    logic [CNT_W-1:0]      recv_count;
    logic [CNT_W-1:0]      send_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic latch;    // capture input word
    logic rd_en;    // table read
    logic calc_jit; // form jitter from previous delay
    logic commit;   // write back and load result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free; // result register empty or being taken
  } dp_status_t;

endpackage

### src/pfdjs_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on pfdjs_pkg for field widths.
interface pfdjs_in_if;
  import pfdjs_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [NODE_W-1:0] node;
  logic [DELAY_W-1:0] delay;
  modport source (output valid, output cmd, output node, output delay, input ready);
  modport sink   (input valid, input cmd, input node, input delay, output ready);
endinterface

interface pfdjs_out_if;
  import pfdjs_pkg::*;
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   node_out;
  logic [JITTER_W-1:0] jitter;
  logic [SUM_W-1:0]    delay_total;
  logic [SUM_W-1:0]    jitter_total;
  logic [CNT_W-1:0]    received;
  logic [CNT_W-1:0]    sent;
  modport source (output valid, output node_out, output jitter, output delay_total,
                  output jitter_total, output received, output sent, input ready);
  modport sink   (input valid, input node_out, input jitter, input delay_total,
                  input jitter_total, input received, input sent, output ready);
endinterface

### src/pfdjs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfdjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pfdjs_ctrl.sv
// Sequencer for the statistics block: accept, table read, jitter, commit.
// Depends on pfdjs_pkg for the command/status structs.
module pfdjs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pfdjs_pkg::dp_status_t status,
  output pfdjs_pkg::dp_cmd_t    cmd
);
  import pfdjs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIFF = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // no word is taken while reset is high
  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next   = state;
    cmd.latch    = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.calc_jit = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !rst) begin
          cmd.latch  = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.calc_jit = 1'b1;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        // hold here until the result register can take the word
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/pfdjs_dp.sv
// Datapath: input capture, per-node table (RAM plus count valid bits),
// jitter and saturating update, result register. Depends on pfdjs_pkg, pfdjs_ram.
module pfdjs_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  pfdjs_pkg::dp_cmd_t       cmd,
  output pfdjs_pkg::dp_status_t    status,
  input  logic [1:0]               cmd_in,
  input  logic [pfdjs_pkg::NODE_W-1:0]  node_in,
  input  logic [pfdjs_pkg::DELAY_W-1:0] delay_in,
  pfdjs_out_if.source              rsp
);
  import pfdjs_pkg::*;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

  logic [1:0]            cmd_r;
  logic [NODE_W-1:0]     node_r;
  logic [DELAY_BITS-1:0] delay_r;
  logic                  in_range_r;
  logic                  recv_v_r;
  logic                  send_v_r;
  logic [DELAY_BITS-1:0] jit_r;

  logic [NODE_COUNT-1:0] recv_valid;
  logic [NODE_COUNT-1:0] send_valid;

  logic [IDX_W-1:0] idx;
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             is_recv;
  logic             is_send;
  logic             we;
  logic [CNT_W-1:0] recv_cnt;
  logic [CNT_W-1:0] send_cnt;
  logic [DELAY_BITS-1:0] prev;

  assign idx     = node_r[IDX_W-1:0];
  assign is_recv = (cmd_r == CMD_RECV);
  assign is_send = (cmd_r == CMD_SEND);
  assign prev    = rd_entry.last_delay;
  // an entry with no valid bit holds a zero count
  assign recv_cnt = recv_v_r ? rd_entry.recv_count : '0;
  assign send_cnt = send_v_r ? rd_entry.send_count : '0;
  assign we       = cmd.commit && in_range_r && (is_recv || is_send);

  assign status.out_free = !rsp.valid || rsp.ready;

  pfdjs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NODE_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(idx),
    .wdata(wr_entry),
    .re   (cmd.rd_en),
    .raddr(idx),
    .rdata(rd_entry)
  );

  always_comb begin
    wr_entry            = rd_entry;
    wr_entry.recv_count = recv_cnt;
    wr_entry.send_count = send_cnt;
    if (is_recv) begin
      wr_entry.last_delay = delay_r;
      if (!recv_v_r) begin
        // first packet from this source
        wr_entry.delay_sum  = SUM_W'(delay_r);
        wr_entry.jitter_sum = '0;
        wr_entry.recv_count = CNT_W'(1);
      end else begin
        wr_entry.delay_sum  = sat_add(rd_entry.delay_sum, SUM_W'(delay_r));
        wr_entry.jitter_sum = sat_add(rd_entry.jitter_sum, SUM_W'(jit_r));
        wr_entry.recv_count = sat_inc(recv_cnt);
      end
    end else if (is_send) begin
      wr_entry.send_count = sat_inc(send_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r      <= cmd_in;
      node_r     <= node_in;
      delay_r    <= delay_in[DELAY_BITS-1:0];
      in_range_r <= (int'(node_in) < NODE_COUNT);
    end
    if (cmd.rd_en) begin
      recv_v_r <= recv_valid[idx];
      send_v_r <= send_valid[idx];
    end
    if (cmd.calc_jit) begin
      if (is_recv && recv_v_r) begin
        jit_r <= (delay_r >= prev) ? delay_r - prev : prev - delay_r;
      end else begin
        jit_r <= '0;
      end
    end
    if (cmd.commit) begin
      rsp.node_out <= node_r;
      if (in_range_r) begin
        rsp.jitter       <= JITTER_W'(jit_r);
        rsp.delay_total  <= wr_entry.delay_sum;
        rsp.jitter_total <= wr_entry.jitter_sum;
        rsp.received     <= wr_entry.recv_count;
        rsp.sent         <= wr_entry.send_count;
      end else begin
        rsp.jitter       <= '0;
        rsp.delay_total  <= '0;
        rsp.jitter_total <= '0;
        rsp.received     <= '0;
        rsp.sent         <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recv_valid <= '0;
      send_valid <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (we && is_recv) begin
        recv_valid[idx] <= 1'b1;
      end
      if (we && is_send) begin
        send_valid[idx] <= 1'b1;
      end
      if (cmd.commit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

### src/per_flow_delay_jitter_stats.sv
// Per-node delay/jitter statistics table.
// Channels: req carries cmd, node, delay (cmd 0 receive record, 1 send record,
// 2 or 3 read); rsp carries one word per request with the entry after update:
// node_out, jitter, delay_total, jitter_total, received, sent.
// Each request passes through capture at the accepting edge, table
// read (registered RAM read), jitter subtract, then the 48-bit saturating update
// with write-back and result load, which raises rsp.valid.
// One request is in flight at a time, as the read-modify-write sequence on the
// single table RAM requires; the next request is taken only after the commit.
// A finished word waits in the rsp register; the next request is taken and
// worked on meanwhile, and holds at the commit step while rsp is stalled.
// Reset (rst, synchronous) clears the receive and send counters of every node
// at once through per-node valid bits; delay history and sums are undefined
// until the first receive record for a node. No clearing pass is needed.
// req.ready stays low while rst is high.
// Depends on pfdjs_pkg, pfdjs_if, pfdjs_ram, pfdjs_ctrl, pfdjs_dp.
module per_flow_delay_jitter_stats (
  input  logic        clk,
  input  logic        rst,
  pfdjs_in_if.sink    req,
  pfdjs_out_if.source rsp
);
  import pfdjs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign req.ready = in_ready;

  pfdjs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  pfdjs_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .cmd_in  (req.cmd),
    .node_in (req.node),
    .delay_in(req.delay),
    .rsp     (rsp)
  );

endmodule

### src/pfdjs_checker.sv
// Port-level checker for the statistics block, bound to the top level.
// Depends on pfdjs_pkg and per_flow_delay_jitter_stats_defines.svh.
`include "per_flow_delay_jitter_stats_defines.svh"

module pfdjs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [pfdjs_pkg::NODE_W-1:0]   node_out,
  input logic [pfdjs_pkg::JITTER_W-1:0] jitter,
  input logic [pfdjs_pkg::CNT_W-1:0]    received
);
  import pfdjs_pkg::*;

  logic rsp_stall;
  logic req_take;
  logic few_received;

  assign rsp_stall    = rsp_valid && !rsp_ready;
  assign req_take     = req_valid && req_ready;
  assign few_received = (received == CNT_W'(0)) || (received == CNT_W'(1));

  // stalled word stays put
  `PFDJS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(node_out) && $stable(received), "rsp word changed while stalled")

  // only one request in flight
  `PFDJS_ASSERT_NEXT(a_one_in_flight, clk, rst, req_take, !req_ready, "request taken while busy")

  // no jitter without a previous delay from that node
  `PFDJS_ASSERT_NOW(a_first_jitter, clk, rst, rsp_valid && few_received, jitter == JITTER_W'(0), "jitter reported without history")

endmodule

bind per_flow_delay_jitter_stats pfdjs_checker u_pfdjs_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .node_out (rsp.node_out),
  .jitter   (rsp.jitter),
  .received (rsp.received)
);
